FILE: rtl/core/mfo_pkg.sv
`timescale 1ns / 1ps
package mfo_pkg;

  localparam int MAX_FACES_DEF    = 4096;
  localparam int MAX_ADJACENT_DEF = 3;
  localparam int STACK_DEPTH_DEF  = 16384;
  localparam int NORMAL_WIDTH_DEF = 16;

  localparam int IDX_W   = 12;  // face index field width
  localparam int CNT_W   = 2;   // neighbor count field width
  localparam int FIELD_W = 16;  // normal component field width
  localparam int TAG_W   = 6;   // walk epoch tag width

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_START,
    S_POP,
    S_POPW,
    S_CURW,
    S_NB,
    S_NBW,
    S_MUL,
    S_PUSH
  } fsm_t;

endpackage

FILE: rtl/core/mfo_if.sv
`timescale 1ns / 1ps
interface mfo_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [mfo_pkg::FIELD_W-1:0]  normal_x;
  logic signed [mfo_pkg::FIELD_W-1:0]  normal_y;
  logic signed [mfo_pkg::FIELD_W-1:0]  normal_z;
  logic        [mfo_pkg::IDX_W-1:0]    adj_first;
  logic        [mfo_pkg::IDX_W-1:0]    adj_second;
  logic        [mfo_pkg::IDX_W-1:0]    adj_third;
  logic        [mfo_pkg::CNT_W-1:0]    adj_count;
  logic                                final_face;
  logic        [mfo_pkg::IDX_W-1:0]    query_face;

  modport source (output valid, req_type, normal_x, normal_y, normal_z, adj_first,
                  adj_second, adj_third, adj_count, final_face, query_face,
                  input ready);
  modport sink (input valid, req_type, normal_x, normal_y, normal_z, adj_first,
                adj_second, adj_third, adj_count, final_face, query_face,
                output ready);
endinterface

interface mfo_out_if;
  logic valid;
  logic ready;
  logic outside_flag;
  logic face_known;
  logic stack_overflow;

  modport source (output valid, outside_flag, face_known, stack_overflow, input ready);
  modport sink (input valid, outside_flag, face_known, stack_overflow, output ready);
endinterface

FILE: rtl/core/mfo_ram.sv
`timescale 1ns / 1ps
module mfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/mesh_face_orientation_flood.sv
`timescale 1ns / 1ps
// Channel  Dir  Word                                             Handshake
// in_ch    in   req_type, normal_x/y/z, adj_*, final_face, query  valid/ready
// out_ch   out  outside_flag, face_known, stack_overflow          valid/ready
//
// A load is written to the face RAMs as it is accepted; a read goes through the state RAM
// read, then the output register. A final load runs the walk: each pop passes S_POP,
// S_POPW and S_CURW; a neighbor ends in S_NB if out of range, in S_NBW if visited, else
// runs S_MUL and S_PUSH. Reset runs a clearing pass over all MAX_FACES state RAM entries;
// the same pass reruns before a walk whenever the epoch tag wraps (every 2^TAG_W-1 walks).
// in_ch.ready is low while clearing, walking or reading, and while a result waits unread.
module mesh_face_orientation_flood #(
  parameter int MAX_FACES    = mfo_pkg::MAX_FACES_DEF,
  parameter int MAX_ADJACENT = mfo_pkg::MAX_ADJACENT_DEF,
  parameter int STACK_DEPTH  = mfo_pkg::STACK_DEPTH_DEF,
  parameter int NORMAL_WIDTH = mfo_pkg::NORMAL_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mfo_in_if.sink    in_ch,
  mfo_out_if.source out_ch
);
  localparam int AW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FCW  = $clog2(MAX_FACES + 1);
  localparam int CW   = (FCW > mfo_pkg::IDX_W) ? FCW : mfo_pkg::IDX_W;
  localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int NW   = NORMAL_WIDTH;
  localparam int NRMW = 3 * NW;
  localparam int ADJL = 3 * mfo_pkg::IDX_W;
  localparam int ADJW = ADJL + mfo_pkg::CNT_W;
  localparam int TW   = mfo_pkg::TAG_W;
  localparam int STW  = TW + 2;        // {tag, visited, flag}
  localparam int PW   = 2 * NW;
  localparam int ACW  = PW + 2;

  mfo_pkg::fsm_t state_r, state_nxt;

  logic [SPW-1:0]  sp_r, sp_nxt;
  logic [FCW-1:0]  fc_r, fc_nxt;
  logic            ovf_r, ovf_nxt;
  logic [TW-1:0]   epoch_r, epoch_nxt;
  logic            live_r, live_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   nb_r, nb_nxt;
  logic [NRMW-1:0] curn_r, curn_nxt;
  logic [NRMW-1:0] nbn_r, nbn_nxt;
  logic [ADJL-1:0] adj_r, adj_nxt;
  logic [1:0]      len_r, len_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [1:0]      m_r, m_nxt;
  logic            curflag_r, curflag_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [ACW-1:0] acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_flag_r, out_flag_nxt;
  logic            out_known_r, out_known_nxt;
  logic            known_r, known_nxt;

  // RAM ports
  logic            nrm_we, adj_we, st_we, stk_we;
  logic [AW-1:0]   nrm_wa, nrm_ra, adj_ra, st_wa, st_ra;
  logic [NRMW-1:0] nrm_wd, nrm_rd;
  logic [ADJW-1:0] adj_wd, adj_rd;
  logic [STW-1:0]  st_wd, st_rd;
  logic [SW-1:0]   stk_wa, stk_ra;
  logic [mfo_pkg::IDX_W-1:0] stk_wd, stk_rd;

  mfo_ram #(.WIDTH(NRMW), .DEPTH(MAX_FACES)) u_nrm (
    .clk, .we(nrm_we), .waddr(nrm_wa), .wdata(nrm_wd), .raddr(nrm_ra), .rdata(nrm_rd));
  mfo_ram #(.WIDTH(ADJW), .DEPTH(MAX_FACES)) u_adj (
    .clk, .we(adj_we), .waddr(nrm_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  mfo_ram #(.WIDTH(STW), .DEPTH(MAX_FACES)) u_st (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  mfo_ram #(.WIDTH(mfo_pkg::IDX_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

  logic in_fire, out_fire;
  logic [mfo_pkg::IDX_W-1:0] nb_idx;
  logic [1:0] cnt_lim;
  logic st_match;
  logic cur_flag_rd;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign in_ch.ready = (state_r == mfo_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.outside_flag   = out_flag_r;
  assign out_ch.face_known     = out_known_r;
  assign out_ch.stack_overflow = ovf_r;

  assign nb_idx   = adj_r[k_r*mfo_pkg::IDX_W +: mfo_pkg::IDX_W];
  // an entry counts only if written in the current walk epoch
  assign st_match = (st_rd[STW-1 -: TW] == epoch_r);
  assign cur_flag_rd = st_match && st_rd[0];
  assign cnt_lim  = (MAX_ADJACENT < 3 && int'(in_ch.adj_count) > MAX_ADJACENT)
                    ? 2'(MAX_ADJACENT) : in_ch.adj_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfo_pkg::S_CLEAR;
      sp_r        <= '0;
      fc_r        <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= '0;
      live_r      <= 1'b0;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      fc_r        <= fc_nxt;
      ovf_r       <= ovf_nxt;
      epoch_r     <= epoch_nxt;
      live_r      <= live_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    nb_r        <= nb_nxt;
    curn_r      <= curn_nxt;
    nbn_r       <= nbn_nxt;
    adj_r       <= adj_nxt;
    len_r       <= len_nxt;
    k_r         <= k_nxt;
    m_r         <= m_nxt;
    curflag_r   <= curflag_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    out_flag_r  <= out_flag_nxt;
    out_known_r <= out_known_nxt;
    known_r     <= known_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    fc_nxt        = fc_r;
    ovf_nxt       = ovf_r;
    epoch_nxt     = epoch_r;
    live_nxt      = live_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    nb_nxt        = nb_r;
    curn_nxt      = curn_r;
    nbn_nxt       = nbn_r;
    adj_nxt       = adj_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    curflag_nxt   = curflag_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_flag_nxt  = out_flag_r;
    out_known_nxt = out_known_r;
    known_nxt     = known_r;
    out_valid_nxt = out_valid_r && !out_fire;

    nrm_we = 1'b0;
    adj_we = 1'b0;
    st_we  = 1'b0;
    stk_we = 1'b0;
    nrm_wa = AW'(fc_r);
    nrm_wd = {NW'($unsigned(in_ch.normal_z)), NW'($unsigned(in_ch.normal_y)),
              NW'($unsigned(in_ch.normal_x))};
    adj_wd = {cnt_lim, in_ch.adj_third, in_ch.adj_second, in_ch.adj_first};
    nrm_ra = cur_r;
    adj_ra = cur_r;
    st_ra  = cur_r;
    st_wa  = cur_r;
    st_wd  = '0;
    stk_wa = SW'(sp_r);
    stk_ra = SW'(sp_r - SPW'(1));
    stk_wd = '0;

    unique case (state_r)
      mfo_pkg::S_CLEAR: begin
        st_we  = 1'b1;
        st_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_FACES - 1)) begin
          clr_nxt   = '0;
          epoch_nxt = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? mfo_pkg::S_START : mfo_pkg::S_IDLE;
        end
      end
      mfo_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type == mfo_pkg::REQ_LOAD) begin
            live_nxt = 1'b0;
            if (int'(fc_r) < MAX_FACES) begin
              nrm_we = 1'b1;
              adj_we = 1'b1;
              fc_nxt = fc_r + FCW'(1);
            end
            if (in_ch.final_face) begin
              state_nxt = mfo_pkg::S_START;
            end
          end else begin
            known_nxt = (CW'(in_ch.query_face) < CW'(fc_r));
            st_ra     = AW'(in_ch.query_face);
            state_nxt = mfo_pkg::S_RD;
          end
        end
      end
      mfo_pkg::S_RD: begin
        out_valid_nxt = 1'b1;
        out_known_nxt = known_r;
        out_flag_nxt  = known_r && live_r && cur_flag_rd;
        state_nxt     = mfo_pkg::S_IDLE;
      end
      mfo_pkg::S_START: begin
        if (epoch_r == {TW{1'b1}}) begin
          // tag space used up: wipe the state RAM first
          pend_nxt  = 1'b1;
          state_nxt = mfo_pkg::S_CLEAR;
        end else begin
          epoch_nxt = epoch_r + TW'(1);
          live_nxt  = 1'b1;
          st_we     = 1'b1;
          st_wa     = '0;
          st_wd     = {epoch_r + TW'(1), 1'b0, 1'b1};
          stk_we    = 1'b1;
          stk_wa    = '0;
          sp_nxt    = SPW'(1);
          state_nxt = mfo_pkg::S_POP;
        end
      end
      mfo_pkg::S_POP: begin
        if (sp_r == '0) begin
          state_nxt = mfo_pkg::S_IDLE;
        end else begin
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = mfo_pkg::S_POPW;
        end
      end
      mfo_pkg::S_POPW: begin
        if (CW'(stk_rd) < CW'(fc_r)) begin
          cur_nxt   = AW'(stk_rd);
          nrm_ra    = AW'(stk_rd);
          adj_ra    = AW'(stk_rd);
          st_ra     = AW'(stk_rd);
          state_nxt = mfo_pkg::S_CURW;
        end else begin
          state_nxt = mfo_pkg::S_POP;
        end
      end
      mfo_pkg::S_CURW: begin
        curn_nxt    = nrm_rd;
        adj_nxt     = adj_rd[ADJL-1:0];
        len_nxt     = adj_rd[ADJW-1 -: 2];
        curflag_nxt = cur_flag_rd;
        st_we       = 1'b1;
        st_wa       = cur_r;
        st_wd       = {epoch_r, 1'b1, cur_flag_rd};
        k_nxt       = '0;
        state_nxt   = mfo_pkg::S_NB;
      end
      mfo_pkg::S_NB: begin
        if (k_r >= len_r) begin
          state_nxt = mfo_pkg::S_POP;
        end else if (CW'(nb_idx) < CW'(fc_r)) begin
          nb_nxt    = AW'(nb_idx);
          nrm_ra    = AW'(nb_idx);
          st_ra     = AW'(nb_idx);
          state_nxt = mfo_pkg::S_NBW;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      mfo_pkg::S_NBW: begin
        if (st_match && st_rd[1]) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = mfo_pkg::S_NB;
        end else begin
          nbn_nxt   = nrm_rd;
          m_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = mfo_pkg::S_MUL;
        end
      end
      mfo_pkg::S_MUL: begin
        // multiply one component per cycle, accumulate the previous product
        if (m_r != 2'd0) begin
          acc_nxt = acc_r + ACW'(prod_r);
        end
        if (m_r == 2'd3) begin
          state_nxt = mfo_pkg::S_PUSH;
        end else begin
          prod_nxt = $signed(curn_r[m_r*NW +: NW]) * $signed(nbn_r[m_r*NW +: NW]);
          m_nxt    = m_r + 2'd1;
        end
      end
      mfo_pkg::S_PUSH: begin
        st_we  = 1'b1;
        st_wa  = nb_r;
        st_wd  = {epoch_r, 1'b0, (acc_r > 0) ? curflag_r : !curflag_r};
        if (int'(sp_r) < STACK_DEPTH) begin
          stk_we = 1'b1;
          stk_wd = mfo_pkg::IDX_W'(nb_r);
          sp_nxt = sp_r + SPW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        k_nxt     = k_r + 2'd1;
        state_nxt = mfo_pkg::S_NB;
      end
      default: state_nxt = mfo_pkg::S_IDLE;
    endcase
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(sp_r) <= STACK_DEPTH) else $error("stack pointer past depth");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mfo_pkg::S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag dropped");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !out_valid_r) |-> (state_r == mfo_pkg::S_RD))
    else $error("result without read");
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fc_r) <= MAX_FACES) else $error("face count past capacity");
endmodule

FILE: bench/tb_mesh_face_orientation_flood.sv
`timescale 1ns / 1ps
// Testbench for the mesh face orientation flood block.
//
// A queue of face loads and flag reads is filled up front. A clocked driver
// feeds it to the block, and a clocked monitor checks each read answer against
// a local copy of the walk. The copy is updated at the moment a word is
// accepted on the input channel.
module tb_mesh_face_orientation_flood;

  localparam int FACES_CAP   = mfo_pkg::MAX_FACES_DEF;
  localparam int STACK_CAP   = mfo_pkg::STACK_DEPTH_DEF;
  localparam int RANDOM_REQS = 1500;
  localparam int QUIET_TAIL  = 150;   // no idling once this few requests remain
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int HOLD_AFTER  = 40;    // answers checked before the hold-off starts

  typedef struct {
    logic                              rtype;
    logic signed [mfo_pkg::FIELD_W-1:0] nx, ny, nz;
    logic [mfo_pkg::IDX_W-1:0]          a0, a1, a2;
    logic [mfo_pkg::CNT_W-1:0]          cnt;
    logic                               fin;
    logic [mfo_pkg::IDX_W-1:0]          q;
  } face_req_t;

  typedef struct {
    logic outside;
    logic known;
    logic ovf;
  } flag_answer_t;

  logic clk;
  logic rst_n;

  mfo_in_if  in_bus ();
  mfo_out_if out_bus ();

  mesh_face_orientation_flood u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Local copy of the face store and the walk state.
  longint           face_nx [FACES_CAP];
  longint           face_ny [FACES_CAP];
  longint           face_nz [FACES_CAP];
  int unsigned      face_adj [FACES_CAP][3];
  int unsigned      face_adj_len [FACES_CAP];
  bit               face_flag [FACES_CAP];
  bit               face_seen [FACES_CAP];
  int unsigned      walk_stk [STACK_CAP];
  int unsigned      loaded_faces;
  bit               overflow_sticky;

  face_req_t        pending_reqs[$];
  flag_answer_t     flag_answers[$];
  face_req_t        cur_req;

  int               fail_count;
  int               loads_sent, reads_sent, walks_sent;
  int               answers_checked, outside_seen;
  int               in_gap, out_gap;
  logic             hold_on, hold_done;
  int               hold_cnt;
  bit               quiet;

  assign quiet = pending_reqs.size() < QUIET_TAIL;

  // Depth-first walk from face 0; a neighbor takes the popped face's flag on a
  // strictly positive dot product and the inverted flag otherwise.
  task automatic flood_orientation();
    int unsigned sp;
    int unsigned cur;
    int unsigned nb;
    longint      dotp;
    sp = 0;
    if (loaded_faces == 0) return;
    face_flag[0] = 1'b1;
    walk_stk[sp++] = 0;
    while (sp > 0) begin
      sp--;
      cur = walk_stk[sp];
      if (cur >= loaded_faces) continue;
      face_seen[cur] = 1'b1;
      for (int k = 0; k < face_adj_len[cur]; k++) begin
        nb = face_adj[cur][k];
        if (nb >= loaded_faces || face_seen[nb]) continue;
        dotp = face_nx[cur] * face_nx[nb] + face_ny[cur] * face_ny[nb] +
               face_nz[cur] * face_nz[nb];
        face_flag[nb] = (dotp > 0) ? face_flag[cur] : ~face_flag[cur];
        if (sp < STACK_CAP) walk_stk[sp++] = nb;
        else overflow_sticky = 1'b1;
      end
    end
  endtask

  // Apply one accepted word to the local copy; reads queue their answer.
  task automatic apply_face_req(input face_req_t r);
    flag_answer_t ans;
    int unsigned  f;
    if (r.rtype == mfo_pkg::REQ_LOAD) begin
      face_flag = '{default: 1'b0};
      face_seen = '{default: 1'b0};
      if (loaded_faces < FACES_CAP) begin
        f = loaded_faces;
        face_nx[f] = r.nx;
        face_ny[f] = r.ny;
        face_nz[f] = r.nz;
        face_adj[f][0] = r.a0;
        face_adj[f][1] = r.a1;
        face_adj[f][2] = r.a2;
        face_adj_len[f] = (r.cnt > mfo_pkg::MAX_ADJACENT_DEF) ?
                          mfo_pkg::MAX_ADJACENT_DEF : r.cnt;
        loaded_faces = f + 1;
      end
      if (r.fin) flood_orientation();
    end else begin
      ans.known   = (r.q < loaded_faces);
      ans.outside = ans.known ? face_flag[r.q] : 1'b0;
      ans.ovf     = overflow_sticky;
      flag_answers.push_back(ans);
    end
  endtask

  function automatic face_req_t mk_load(input int nx, ny, nz,
                                        input int a0, a1, a2, cnt, fin);
    face_req_t r;
    r.rtype = mfo_pkg::REQ_LOAD;
    r.nx = mfo_pkg::FIELD_W'(nx);
    r.ny = mfo_pkg::FIELD_W'(ny);
    r.nz = mfo_pkg::FIELD_W'(nz);
    r.a0 = mfo_pkg::IDX_W'(a0);
    r.a1 = mfo_pkg::IDX_W'(a1);
    r.a2 = mfo_pkg::IDX_W'(a2);
    r.cnt = mfo_pkg::CNT_W'(cnt);
    r.fin = 1'(fin);
    r.q = mfo_pkg::IDX_W'($urandom);
    return r;
  endfunction

  function automatic face_req_t mk_read(input int q);
    face_req_t r;
    r = mk_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    r.rtype = mfo_pkg::REQ_READ;
    r.q = mfo_pkg::IDX_W'(q);
    return r;
  endfunction

  // Pick a neighbor index: mostly near the faces already loaded, some anywhere.
  function automatic int pick_nb(input int faces);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, faces + 8);
  endfunction

  // Hold all inputs known from time zero.
  initial begin
    in_bus.valid = 1'b0;
    in_bus.req_type = mfo_pkg::REQ_LOAD;
    in_bus.normal_x = '0;
    in_bus.normal_y = '0;
    in_bus.normal_z = '0;
    in_bus.adj_first = '0;
    in_bus.adj_second = '0;
    in_bus.adj_third = '0;
    in_bus.adj_count = '0;
    in_bus.final_face = 1'b0;
    in_bus.query_face = '0;
    out_bus.ready = 1'b0;
  end

  // Driver: advance to the next word after each acceptance, with idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_face_req(cur_req);
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 4);
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.req_type   <= cur_req.rtype;
          in_bus.normal_x   <= cur_req.nx;
          in_bus.normal_y   <= cur_req.ny;
          in_bus.normal_z   <= cur_req.nz;
          in_bus.adj_first  <= cur_req.a0;
          in_bus.adj_second <= cur_req.a1;
          in_bus.adj_third  <= cur_req.a2;
          in_bus.adj_count  <= cur_req.cnt;
          in_bus.final_face <= cur_req.fin;
          in_bus.query_face <= cur_req.q;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side so that the block backs up its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_on   <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (!hold_done && !hold_on && answers_checked >= HOLD_AFTER) begin
      hold_on  <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_on) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: check each accepted answer against the oldest queued one.
  always @(posedge clk) begin
    flag_answer_t exp_ans;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (flag_answers.size() == 0) begin
          $error("answer with nothing expected: outside_flag=%0b face_known=%0b",
                 out_bus.outside_flag, out_bus.face_known);
          fail_count++;
        end else begin
          exp_ans = flag_answers.pop_front();
          answers_checked++;
          if (out_bus.outside_flag) outside_seen++;
          if (out_bus.outside_flag !== exp_ans.outside) begin
            $error("outside_flag expected %0b got %0b", exp_ans.outside,
                   out_bus.outside_flag);
            fail_count++;
          end
          if (out_bus.face_known !== exp_ans.known) begin
            $error("face_known expected %0b got %0b", exp_ans.known, out_bus.face_known);
            fail_count++;
          end
          if (out_bus.stack_overflow !== exp_ans.ovf) begin
            $error("stack_overflow expected %0b got %0b", exp_ans.ovf,
                   out_bus.stack_overflow);
            fail_count++;
          end
        end
      end
      if (hold_on) begin
        out_bus.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 4) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int gen_faces;
    int fin;
    face_req_t r;
    fail_count = 0;
    loaded_faces = 0;
    overflow_sticky = 1'b0;
    face_flag = '{default: 1'b0};
    face_seen = '{default: 1'b0};
    in_gap = 0;
    out_gap = 0;
    answers_checked = 0;
    outside_seen = 0;
    rst_n = 1'b0;

    // Directed: read before any load, extreme normals, zero and negative dot
    // products, out-of-range neighbors, every neighbor count, repeated walks.
    pending_reqs.push_back(mk_read(0));
    pending_reqs.push_back(mk_load(16'sh7fff, 0, 0, 1, 2, 4095, 3, 0));
    pending_reqs.push_back(mk_load(-16'sh8000, 0, 0, 0, 2, 3, 2, 0));
    pending_reqs.push_back(mk_load(0, 16'sh7fff, 0, 0, 1, 0, 1, 0));
    pending_reqs.push_back(mk_load(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 1));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(mk_read(i));
    pending_reqs.push_back(mk_read(4095));
    pending_reqs.push_back(mk_load(-16'sh8000, -16'sh8000, -16'sh8000, 0, 3, 4095, 3, 0));
    pending_reqs.push_back(mk_read(0));
    pending_reqs.push_back(mk_load(16'sh0001, -16'sh0001, 0, 4, 4, 4, 3, 1));
    for (int i = 0; i < 7; i++) pending_reqs.push_back(mk_read(i));
    gen_faces = 6;
    loads_sent = 6;
    reads_sent = 15;
    walks_sent = 2;

    // Random mix: faces appended with mostly nearby neighbors, occasional
    // walks, reads mostly of loaded faces.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        fin = ($urandom_range(0, 9) == 0);
        pending_reqs.push_back(mk_load($urandom, $urandom, $urandom, pick_nb(gen_faces),
                                       pick_nb(gen_faces), pick_nb(gen_faces),
                                       $urandom_range(0, 3), fin));
        gen_faces++;
        loads_sent++;
        walks_sent += fin;
      end else begin
        if ($urandom_range(0, 6) == 0) r = mk_read($urandom_range(0, 4095));
        else r = mk_read($urandom_range(0, gen_faces));
        pending_reqs.push_back(r);
        reads_sent++;
      end
    end

    // One last load that starts a walk from face 0, then reads of random face indices.
    pending_reqs.push_back(mk_load($urandom, $urandom, $urandom, 0, 1, 2, 3, 1));
    loads_sent++;
    walks_sent++;
    for (int i = 0; i < 60; i++) pending_reqs.push_back(mk_read($urandom_range(0, 4095)));
    reads_sent += 60;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_bus.valid);
    wait (flag_answers.size() == 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d face loads (%0d walks) and %0d flag reads.",
             loads_sent, walks_sent, reads_sent);
    $display("Checked %0d answers, %0d of them outward.", answers_checked, outside_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
